FILE: sv/sns_pkg.sv
`default_nettype none

package sns_pkg;

  localparam int unsigned SNS_COUNT_WIDTH = 32;
  localparam int unsigned SNS_QUEUE_DEPTH = 2;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAP_MIN = 1'b0,
    CFG_BRK_RUN = 1'b1
  } sns_cfg_idx_e;

  localparam logic [15:0] GAP_MIN_RESET = 16'd9;
  localparam logic [16:0] BRK_RUN_RESET = 17'h1FFFF;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_EOF  = 1'b1;

  localparam logic REC_CONTIG   = 1'b0;
  localparam logic REC_SCAFFOLD = 1'b1;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_HEADER  = 8'h3E;
  localparam logic [7:0] CH_N_UPPER = 8'h4E;
  localparam logic [7:0] CH_N_LOWER = 8'h6E;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_byte;
  } sns_in_t;

  typedef struct packed {
    logic        record_kind;
    logic [31:0] contig_bases;
    logic [31:0] contig_short_n;
    logic [31:0] gap_before;
    logic [31:0] scaffold_length;
    logic [31:0] scaffold_contigs;
    logic [31:0] scaffold_contig_bases;
    logic        last_record;
  } sns_out_t;

  // One queue entry holds everything that a single byte closes.
  typedef struct packed {
    logic        emit_ct;
    logic        emit_sc;
    logic [31:0] ct_bases;
    logic [31:0] ct_short_n;
    logic [31:0] ct_gap;
    logic [31:0] sc_len;
    logic [31:0] sc_cnt;
    logic [31:0] sc_sum;
  } sns_qent_t;

endpackage

`default_nettype wire

FILE: sv/sns_front.sv
`default_nettype none

module sns_front import sns_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = SNS_COUNT_WIDTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  input  wire sns_in_t               in_data_i,
  input  wire logic                  q_full_i,
  output logic                       in_stall_o,
  output logic                       q_push_o,
  output sns_qent_t                  q_data_o
);

  localparam int unsigned W = COUNT_WIDTH;

  function automatic logic [W-1:0] sat_add(logic [W-1:0] a, logic [W-1:0] b, logic cin);
    logic [W+1:0] s;
    s = {2'b00, a} + {2'b00, b} + {{(W+1){1'b0}}, cin};
    return (s[W+1:W] != 2'b00) ? {W{1'b1}} : s[W-1:0];
  endfunction

  logic [15:0]  gap_min_q;
  logic [16:0]  brk_run_q;
  logic         at_line_q, at_line_d;
  logic         in_hdr_q, in_hdr_d;
  logic [W-1:0] run_q, run_d;
  logic [W-1:0] c_total_q, c_total_d;
  logic [W-1:0] c_n_q, c_n_d;
  logic [W-1:0] pend_gap_q, pend_gap_d;
  logic [W-1:0] s_total_q, s_total_d;
  logic [W-1:0] s_cnt_q, s_cnt_d;
  logic [W-1:0] s_sum_q, s_sum_d;

  logic         accept;
  logic         is_eof, is_hdr, is_nl, is_gt, is_n, is_other;
  logic         do_end_run, brk_match, brk_hit, gap_hit, short_hit;
  logic         close_sc, close_ct, kept, emit_sc;
  logic [W-1:0] bases, s_cnt_new, s_sum_new, s_total_eff;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_min_q <= GAP_MIN_RESET;
      brk_run_q <= BRK_RUN_RESET;
    end else if (cfg_we_i) begin
      case (sns_cfg_idx_e'(cfg_idx_i))
        CFG_GAP_MIN: gap_min_q <= cfg_data_i[15:0];
        CFG_BRK_RUN: brk_run_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Byte classification, in priority order.
  always_comb begin
    is_eof   = (in_data_i.mode == MODE_EOF);
    is_hdr   = !is_eof && in_hdr_q;
    is_nl    = !is_eof && !in_hdr_q && (in_data_i.char_byte == CH_NEWLINE);
    is_gt    = !is_eof && !in_hdr_q && !is_nl && at_line_q &&
               (in_data_i.char_byte == CH_HEADER);
    is_n     = !is_eof && !in_hdr_q && !is_nl && !is_gt &&
               (in_data_i.char_byte inside {CH_N_UPPER, CH_N_LOWER});
    is_other = !is_eof && !in_hdr_q && !is_nl && !is_gt && !is_n;
  end

  always_comb begin
    do_end_run = (run_q != '0) && ((is_nl && at_line_q) || is_other);
    brk_match  = !brk_run_q[16] && (run_q == W'(brk_run_q[15:0]));
    brk_hit    = do_end_run && brk_match;
    gap_hit    = do_end_run && !brk_match && (run_q >= W'(gap_min_q));
    short_hit  = do_end_run && !brk_match && !gap_hit;

    close_sc   = is_eof || is_gt || brk_hit;
    close_ct   = close_sc || gap_hit;
    kept       = close_ct && (c_total_q != c_n_q);
    bases      = c_total_q - c_n_q;
    s_cnt_new  = kept ? sat_add(s_cnt_q, '0, 1'b1) : s_cnt_q;
    s_sum_new  = kept ? sat_add(s_sum_q, bases, 1'b0) : s_sum_q;
    // A break run is taken back out of the scaffold it closes.
    if (brk_hit) begin
      s_total_eff = (run_q > s_total_q) ? '0 : s_total_q - run_q;
    end else begin
      s_total_eff = s_total_q;
    end
    emit_sc    = close_sc && (s_cnt_new != '0);
  end

  always_comb begin
    at_line_d  = at_line_q;
    in_hdr_d   = in_hdr_q;
    run_d      = run_q;
    c_total_d  = c_total_q;
    c_n_d      = c_n_q;
    pend_gap_d = pend_gap_q;
    s_total_d  = s_total_q;
    s_cnt_d    = s_cnt_q;
    s_sum_d    = s_sum_q;

    if (is_eof) begin
      at_line_d = 1'b1;
      in_hdr_d  = 1'b0;
    end else if (is_hdr) begin
      if (in_data_i.char_byte == CH_NEWLINE) begin
        at_line_d = 1'b1;
        in_hdr_d  = 1'b0;
      end
    end else if (is_nl) begin
      at_line_d = 1'b1;
    end else if (is_gt) begin
      at_line_d = 1'b0;
      in_hdr_d  = 1'b1;
    end else begin
      at_line_d = 1'b0;
    end

    if (is_n) begin
      run_d = sat_add(run_q, '0, 1'b1);
    end else if (do_end_run || close_sc) begin
      run_d = '0;
    end

    if (close_ct) begin
      c_total_d = is_other ? W'(1) : '0;
      c_n_d     = '0;
    end else begin
      c_total_d = sat_add(c_total_q, short_hit ? run_q : '0, is_other);
      if (short_hit) begin
        c_n_d = sat_add(c_n_q, run_q, 1'b0);
      end
    end

    if (close_sc) begin
      pend_gap_d = '0;
      s_total_d  = is_other ? W'(1) : '0;
      s_cnt_d    = '0;
      s_sum_d    = '0;
    end else begin
      if (gap_hit && kept) begin
        pend_gap_d = run_q;
      end
      if (is_n || is_other) begin
        s_total_d = sat_add(s_total_q, '0, 1'b1);
      end
      s_cnt_d = s_cnt_new;
      s_sum_d = s_sum_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_line_q  <= 1'b1;
      in_hdr_q   <= 1'b0;
      run_q      <= '0;
      c_total_q  <= '0;
      c_n_q      <= '0;
      pend_gap_q <= '0;
      s_total_q  <= '0;
      s_cnt_q    <= '0;
      s_sum_q    <= '0;
    end else if (accept) begin
      at_line_q  <= at_line_d;
      in_hdr_q   <= in_hdr_d;
      run_q      <= run_d;
      c_total_q  <= c_total_d;
      c_n_q      <= c_n_d;
      pend_gap_q <= pend_gap_d;
      s_total_q  <= s_total_d;
      s_cnt_q    <= s_cnt_d;
      s_sum_q    <= s_sum_d;
    end
  end

  always_comb begin
    q_push_o            = accept && (kept || emit_sc);
    q_data_o.emit_ct    = kept;
    q_data_o.emit_sc    = emit_sc;
    q_data_o.ct_bases   = 32'(bases);
    q_data_o.ct_short_n = 32'(c_n_q);
    q_data_o.ct_gap     = 32'(pend_gap_q);
    q_data_o.sc_len     = 32'(s_total_eff);
    q_data_o.sc_cnt     = 32'(s_cnt_new);
    q_data_o.sc_sum     = 32'(s_sum_new);
  end

endmodule

`default_nettype wire

FILE: sv/sns_queue.sv
`default_nettype none

module sns_queue import sns_pkg::*; #(
  parameter int unsigned DEPTH = SNS_QUEUE_DEPTH
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire sns_qent_t push_data_i,
  input  wire logic      pop_i,
  output logic           full_o,
  output logic           valid_o,
  output sns_qent_t      head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sns_qent_t          mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/sns_back.sv
`default_nettype none

module sns_back import sns_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      q_valid_i,
  input  wire sns_qent_t q_head_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output sns_out_t       out_data_o
);

  logic     out_valid_q;
  sns_out_t out_q;
  logic     sc_pend_q;
  sns_out_t sc_rec_q;
  logic     out_free;
  sns_out_t ct_rec, sc_rec;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign q_pop_o     = out_free && !sc_pend_q && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    ct_rec                       = '0;
    ct_rec.record_kind           = REC_CONTIG;
    ct_rec.contig_bases          = q_head_i.ct_bases;
    ct_rec.contig_short_n        = q_head_i.ct_short_n;
    ct_rec.gap_before            = q_head_i.ct_gap;
    ct_rec.last_record           = !q_head_i.emit_sc;

    sc_rec                       = '0;
    sc_rec.record_kind           = REC_SCAFFOLD;
    sc_rec.scaffold_length       = q_head_i.sc_len;
    sc_rec.scaffold_contigs      = q_head_i.sc_cnt;
    sc_rec.scaffold_contig_bases = q_head_i.sc_sum;
    sc_rec.last_record           = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sc_pend_q   <= 1'b0;
    end else if (out_free) begin
      if (sc_pend_q) begin
        out_valid_q <= 1'b1;
        sc_pend_q   <= 1'b0;
      end else if (q_valid_i) begin
        out_valid_q <= 1'b1;
        sc_pend_q   <= q_head_i.emit_ct && q_head_i.emit_sc;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // When an entry closes both a contig and its scaffold, the contig beat goes
  // first and the scaffold beat waits here.
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (sc_pend_q) begin
        out_q <= sc_rec_q;
      end else if (q_valid_i) begin
        out_q    <= q_head_i.emit_ct ? ct_rec : sc_rec;
        sc_rec_q <= sc_rec;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/sequence_n_run_segmenter_core.sv
`default_nettype none

// Splits a sequence-file byte stream into contigs and scaffolds at runs of N.
// One byte (or end-of-file beat) is accepted per clock; the byte decoder and
// its counters update in that cycle and hand any closed contig or scaffold to
// a short queue, from which the output stage sends one record beat per cycle
// while the output is not stalled. A byte that closes both a contig and a
// scaffold gives two beats and so holds the output stage for both; input
// stalls only when the queue is full, which needs such pairs back to back or
// a stalled output. A record passes through the queue and the output register
// before it appears. Counters are COUNT_WIDTH bits wide and saturate; record
// fields carry their low 32 bits. Configuration writes take effect on the next
// byte and should be made while no records are outstanding.
module sequence_n_run_segmenter_core import sns_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = SNS_COUNT_WIDTH,
  parameter int unsigned QUEUE_DEPTH = SNS_QUEUE_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire sns_in_t               in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output sns_out_t                   out_data_o
);

  logic      q_push, q_full, q_valid, q_pop;
  sns_qent_t q_push_data, q_head;

  sns_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .q_push_o   (q_push),
    .q_data_o   (q_push_data)
  );

  sns_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  sns_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: sv/sns_checker.sv
`default_nettype none

module sns_checker import sns_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_stall_o,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire sns_out_t out_data_o
);

  // A stalled record beat holds until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // A contig beat that is not last is followed at once by its scaffold beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (out_data_o.record_kind == REC_CONTIG) &&
    !out_data_o.last_record
    |=> out_valid_o && (out_data_o.record_kind == REC_SCAFFOLD))
    else $error("scaffold beat did not follow its contig beat");

  // A scaffold record always ends its byte's records and has no contig fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.record_kind == REC_SCAFFOLD)
    |-> out_data_o.last_record && (out_data_o.contig_bases == '0) &&
        (out_data_o.contig_short_n == '0) && (out_data_o.gap_before == '0))
    else $error("malformed scaffold record");

  // Input is only held off while records are waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no output pending");

endmodule

bind sequence_n_run_segmenter_core sns_checker u_sns_checker (.*);

`default_nettype wire
